@@ rtl/ajb_pkg.sv @@
`timescale 1ns / 1ps

package ajb_pkg;

    localparam int FIFO_DEPTH       = 8192;
    localparam int FRAME_SAMPLES    = 1024;
    localparam int FILTER_FRAC_BITS = 16;

    localparam int ADDR_W   = $clog2(FIFO_DEPTH);
    localparam int OCC_W    = ADDR_W + 1;
    localparam int SAMPLE_W = 16;
    localparam int ADC_W    = 12;
    localparam int ALPHA_W  = 16;
    localparam int LEVEL_W  = 14;
    localparam int FILL_W   = 15;
    localparam int FS_W     = ADC_W + FILTER_FRAC_BITS;

    localparam int FRAME_TICKS = (FRAME_SAMPLES + 1) / 2;
    localparam int FPOS_W      = (FRAME_TICKS > 1) ? $clog2(FRAME_TICKS) : 1;

    localparam logic [1:0] REQ_NET    = 2'd0;
    localparam logic [1:0] REQ_TICK   = 2'd1;
    localparam logic [1:0] REQ_TOGGLE = 2'd2;

    localparam logic [1:0] KIND_DAC      = 2'd0;
    localparam logic [1:0] KIND_MIC      = 2'd1;
    localparam logic [1:0] KIND_UNDERRUN = 2'd2;

    localparam logic [15:0] DAC_CFG_A   = 16'h3000;
    localparam logic [15:0] DAC_CFG_B   = 16'hB000;
    localparam logic [15:0] DAC_DATA_MASK = 16'h0FFF;

    localparam logic [LEVEL_W-1:0] START_LEVEL_RST  = LEVEL_W'(512);
    localparam logic [ALPHA_W-1:0] FILTER_ALPHA_RST = ALPHA_W'(26214);
    localparam logic [FS_W-1:0]    FILTER_STATE_RST = FS_W'(2048) << FILTER_FRAC_BITS;

    localparam logic signed [FILL_W:0] FILL_MAX = (FILL_W+1)'(16383);
    localparam logic signed [FILL_W:0] FILL_MIN = -(FILL_W+1)'(16384);

    localparam int APB_ADDR_W = 3;
    localparam logic REG_START_LEVEL  = 1'b0;
    localparam logic REG_FILTER_ALPHA = 1'b1;

    typedef struct packed {
        logic [1:0]          req_type;
        logic [SAMPLE_W-1:0] net_sample;
        logic [ADC_W-1:0]    mic_raw;
    } ajb_in_t;

    typedef struct packed {
        logic [1:0]          result_kind;
        logic [15:0]         dac_word_a;
        logic [15:0]         dac_word_b;
        logic [ADC_W-1:0]    mic_sample;
        logic                frame_end;
    } ajb_out_t;

    typedef struct packed {
        logic tick;
        logic toggle;
    } ajb_tx_ctrl_t;

    typedef struct packed {
        logic [ADC_W-1:0] mic_sample;
        logic             frame_end;
    } ajb_tx_res_t;

endpackage

@@ rtl/ajb_sample_ram.sv @@
`timescale 1ns / 1ps

module ajb_sample_ram #(
    parameter int ADDR_W = 13,
    parameter int DATA_W = 16
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr_a,
    input  logic [ADDR_W-1:0] rd_addr_b,
    output logic [DATA_W-1:0] rd_data_a,
    output logic [DATA_W-1:0] rd_data_b
);

    logic [DATA_W-1:0] mem [0:(1<<ADDR_W)-1];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_a <= mem[rd_addr_a];
            rd_data_b <= mem[rd_addr_b];
        end
    end

endmodule

@@ rtl/ajb_tx_path.sv @@
`timescale 1ns / 1ps

module ajb_tx_path (
    input  logic                          clk,
    input  logic                          rst_n,
    input  ajb_pkg::ajb_tx_ctrl_t         ctrl,
    input  logic [ajb_pkg::ADC_W-1:0]     mic_raw,
    input  logic [ajb_pkg::ALPHA_W-1:0]   filter_alpha,
    output ajb_pkg::ajb_tx_res_t          res
);

    localparam int MIX_W  = ajb_pkg::ALPHA_W + ajb_pkg::ADC_W;
    localparam int PROD_W = ajb_pkg::ALPHA_W + 1 + ajb_pkg::FS_W;
    localparam int ACC_W  = PROD_W + 1;

    logic [ajb_pkg::FS_W-1:0]   filter_state_reg;
    logic [ajb_pkg::FS_W-1:0]   filter_state_next;
    logic [ajb_pkg::FPOS_W-1:0] frame_pos_reg;
    logic [ajb_pkg::FPOS_W-1:0] frame_pos_next;
    logic [ajb_pkg::FPOS_W:0]   frame_pos_inc;
    logic [ajb_pkg::ALPHA_W:0]  alpha_comp;
    logic [MIX_W-1:0]           mix_new;
    logic [PROD_W-1:0]          prod_new;
    logic [PROD_W-1:0]          prod_old;
    logic [ACC_W-1:0]           acc;
    logic                       frame_done;

    // weights sum to one in Q0.16
    assign alpha_comp = (ajb_pkg::ALPHA_W+1)'(1 << ajb_pkg::ALPHA_W)
                        - {1'b0, filter_alpha};
    assign mix_new    = MIX_W'(filter_alpha) * MIX_W'(mic_raw);
    assign prod_new   = PROD_W'(mix_new) << ajb_pkg::FILTER_FRAC_BITS;
    assign prod_old   = PROD_W'(alpha_comp) * PROD_W'(filter_state_reg);
    assign acc        = ACC_W'(prod_new) + ACC_W'(prod_old);

    always_comb
    begin
        filter_state_next = filter_state_reg;
        frame_pos_next    = frame_pos_reg;
        frame_pos_inc     = {1'b0, frame_pos_reg} + 1'b1;
        frame_done        = 1'b0;
        if (ctrl.toggle)
        begin
            frame_pos_next = '0;
        end
        else if (ctrl.tick)
        begin
            filter_state_next = acc[ajb_pkg::ALPHA_W +: ajb_pkg::FS_W];
            if (frame_pos_inc >= (ajb_pkg::FPOS_W+1)'(ajb_pkg::FRAME_TICKS))
            begin
                frame_pos_next = '0;
                frame_done     = 1'b1;
            end
            else
            begin
                frame_pos_next = frame_pos_inc[ajb_pkg::FPOS_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filter_state_reg <= ajb_pkg::FILTER_STATE_RST;
            frame_pos_reg    <= '0;
        end
        else
        begin
            filter_state_reg <= filter_state_next;
            frame_pos_reg    <= frame_pos_next;
        end
    end

    assign res.mic_sample = filter_state_next[ajb_pkg::FILTER_FRAC_BITS +: ajb_pkg::ADC_W];
    assign res.frame_end  = frame_done;

endmodule

@@ rtl/audio_jitter_buffer_endpoint_top.sv @@
`timescale 1ns / 1ps

// Two-way audio endpoint. Network samples go into an 8192-entry sample RAM
// (dropped when full); a saturating fill counter starts playback at
// start_level. In receive mode each tick pops a left/right pair and returns
// two DAC words, or an underrun; in transmit mode each tick returns the
// microphone reading smoothed by an exponential moving average, with a frame
// end every 512 ticks. One item is accepted every cycle: all pointer and
// counter updates happen in the accept cycle, and the dual-read RAM port
// fetches both samples of a tick at once, so the only stall comes from the
// output side. Each result passes through the RAM read, then the output
// register. Configuration sits on an APB port: start_level at 0x0,
// filter_alpha at 0x4.
module audio_jitter_buffer_endpoint_top (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  ajb_pkg::ajb_in_t                   in_data,
    output logic                               out_valid,
    input  logic                               out_ready,
    output ajb_pkg::ajb_out_t                  out_data,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [ajb_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);

    // configuration
    logic [ajb_pkg::LEVEL_W-1:0] start_level_reg;
    logic [ajb_pkg::ALPHA_W-1:0] filter_alpha_reg;
    logic                        cfg_wr;

    // receive state
    logic [ajb_pkg::ADDR_W-1:0]  wr_ptr_reg,  wr_ptr_next;
    logic [ajb_pkg::ADDR_W-1:0]  rd_ptr_reg,  rd_ptr_next;
    logic [ajb_pkg::OCC_W-1:0]   occ_reg,     occ_next;
    logic signed [ajb_pkg::FILL_W-1:0] fill_reg, fill_next;
    logic                        playing_reg, playing_next;
    logic                        tx_mode_reg, tx_mode_next;

    // pipeline
    logic                        s1_valid_reg, s1_valid_next;
    logic [1:0]                  s1_kind_reg,  s1_kind_next;
    ajb_pkg::ajb_tx_res_t        s1_tx_reg;
    logic                        out_valid_reg;
    ajb_pkg::ajb_out_t           out_data_reg;
    ajb_pkg::ajb_out_t           s1_result;

    logic                        in_fire;
    logic                        s1_adv;
    logic                        ram_wr;
    logic                        ram_rd;
    logic [ajb_pkg::ADDR_W-1:0]  rd_ptr_plus1;
    logic [ajb_pkg::SAMPLE_W-1:0] left_sample;
    logic [ajb_pkg::SAMPLE_W-1:0] right_sample;
    logic signed [ajb_pkg::FILL_W:0] fill_sum;
    logic signed [ajb_pkg::FILL_W:0] fill_sat;

    ajb_pkg::ajb_tx_ctrl_t       tx_ctrl;
    ajb_pkg::ajb_tx_res_t        tx_res;

    // ---------------- APB ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb
    begin
        prdata = '0;
        case (paddr[2])
            ajb_pkg::REG_START_LEVEL:  prdata = 32'(start_level_reg);
            ajb_pkg::REG_FILTER_ALPHA: prdata = 32'(filter_alpha_reg);
            default:                   prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_level_reg  <= ajb_pkg::START_LEVEL_RST;
            filter_alpha_reg <= ajb_pkg::FILTER_ALPHA_RST;
        end
        else if (cfg_wr)
        begin
            case (paddr[2])
                ajb_pkg::REG_START_LEVEL:  start_level_reg  <= pwdata[ajb_pkg::LEVEL_W-1:0];
                ajb_pkg::REG_FILTER_ALPHA: filter_alpha_reg <= pwdata[ajb_pkg::ALPHA_W-1:0];
                default:                   ;
            endcase
        end
    end

    // ---------------- handshake ----------------
    assign s1_adv   = !out_valid_reg || out_ready;
    assign in_ready = !s1_valid_reg || s1_adv;
    assign in_fire  = in_valid && in_ready;

    // ---------------- receive control ----------------
    assign rd_ptr_plus1 = rd_ptr_reg + 1'b1;

    always_comb
    begin
        wr_ptr_next   = wr_ptr_reg;
        rd_ptr_next   = rd_ptr_reg;
        occ_next      = occ_reg;
        fill_next     = fill_reg;
        playing_next  = playing_reg;
        tx_mode_next  = tx_mode_reg;
        s1_valid_next = 1'b0;
        s1_kind_next  = ajb_pkg::KIND_DAC;
        ram_wr        = 1'b0;
        ram_rd        = 1'b0;
        tx_ctrl       = '0;
        fill_sum      = {fill_reg[ajb_pkg::FILL_W-1], fill_reg};
        fill_sat      = fill_sum;

        if (in_fire)
        begin
            case (in_data.req_type)
                ajb_pkg::REQ_NET:
                begin
                    if (occ_reg != ajb_pkg::OCC_W'(ajb_pkg::FIFO_DEPTH))
                    begin
                        ram_wr      = 1'b1;
                        wr_ptr_next = wr_ptr_reg + 1'b1;
                        occ_next    = occ_reg + 1'b1;
                        fill_sum    = {fill_reg[ajb_pkg::FILL_W-1], fill_reg} + 1'sb1;
                    end
                    // clamp the counter to its signed range
                    fill_sat = (fill_sum > ajb_pkg::FILL_MAX) ? ajb_pkg::FILL_MAX : fill_sum;
                    fill_next = fill_sat[ajb_pkg::FILL_W-1:0];
                    if (!playing_reg &&
                        (fill_sat >= $signed({2'b00, start_level_reg})))
                    begin
                        playing_next = 1'b1;
                    end
                end
                ajb_pkg::REQ_TOGGLE:
                begin
                    tx_mode_next   = !tx_mode_reg;
                    tx_ctrl.toggle = 1'b1;
                    if (!tx_mode_reg)
                    begin
                        playing_next = 1'b0;
                        fill_next    = '0;
                    end
                end
                ajb_pkg::REQ_TICK:
                begin
                    if (tx_mode_reg)
                    begin
                        tx_ctrl.tick  = 1'b1;
                        s1_valid_next = 1'b1;
                        s1_kind_next  = ajb_pkg::KIND_MIC;
                    end
                    else if (playing_reg)
                    begin
                        s1_valid_next = 1'b1;
                        if (occ_reg < ajb_pkg::OCC_W'(2))
                        begin
                            // half underrun drops the lone sample
                            s1_kind_next = ajb_pkg::KIND_UNDERRUN;
                            playing_next = 1'b0;
                            fill_next    = '0;
                            if (occ_reg != '0)
                            begin
                                rd_ptr_next = rd_ptr_plus1;
                                occ_next    = '0;
                            end
                        end
                        else
                        begin
                            s1_kind_next = ajb_pkg::KIND_DAC;
                            ram_rd       = 1'b1;
                            rd_ptr_next  = rd_ptr_reg + ajb_pkg::ADDR_W'(2);
                            occ_next     = occ_reg - ajb_pkg::OCC_W'(2);
                            fill_sum     = {fill_reg[ajb_pkg::FILL_W-1], fill_reg}
                                           - (ajb_pkg::FILL_W+1)'(2);
                            fill_sat     = (fill_sum < ajb_pkg::FILL_MIN) ?
                                           ajb_pkg::FILL_MIN : fill_sum;
                            fill_next    = fill_sat[ajb_pkg::FILL_W-1:0];
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg  <= '0;
            rd_ptr_reg  <= '0;
            occ_reg     <= '0;
            fill_reg    <= '0;
            playing_reg <= 1'b0;
            tx_mode_reg <= 1'b0;
        end
        else
        begin
            wr_ptr_reg  <= wr_ptr_next;
            rd_ptr_reg  <= rd_ptr_next;
            occ_reg     <= occ_next;
            fill_reg    <= fill_next;
            playing_reg <= playing_next;
            tx_mode_reg <= tx_mode_next;
        end
    end

    ajb_sample_ram #(
        .ADDR_W (ajb_pkg::ADDR_W),
        .DATA_W (ajb_pkg::SAMPLE_W)
    ) u_ram (
        .clk       (clk),
        .wr_en     (ram_wr),
        .wr_addr   (wr_ptr_reg),
        .wr_data   (in_data.net_sample),
        .rd_en     (ram_rd),
        .rd_addr_a (rd_ptr_reg),
        .rd_addr_b (rd_ptr_plus1),
        .rd_data_a (left_sample),
        .rd_data_b (right_sample)
    );

    ajb_tx_path u_tx (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (tx_ctrl),
        .mic_raw      (in_data.mic_raw),
        .filter_alpha (filter_alpha_reg),
        .res          (tx_res)
    );

    // ---------------- result stage ----------------
    always_comb
    begin
        s1_result             = '0;
        s1_result.result_kind = s1_kind_reg;
        case (s1_kind_reg)
            ajb_pkg::KIND_DAC:
            begin
                s1_result.dac_word_a = ajb_pkg::DAC_CFG_A | (left_sample & ajb_pkg::DAC_DATA_MASK);
                s1_result.dac_word_b = ajb_pkg::DAC_CFG_B | (right_sample & ajb_pkg::DAC_DATA_MASK);
            end
            ajb_pkg::KIND_MIC:
            begin
                s1_result.mic_sample = s1_tx_reg.mic_sample;
                s1_result.frame_end  = s1_tx_reg.frame_end;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                s1_valid_reg <= s1_valid_next;
            end
            if (s1_adv)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready)
        begin
            s1_kind_reg <= s1_kind_next;
            s1_tx_reg   <= tx_res;
        end
        if (s1_adv && s1_valid_reg)
        begin
            out_data_reg <= s1_result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

@@ rtl/ajb_checker.sv @@
`timescale 1ns / 1ps

module ajb_checker (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              out_valid,
    input  logic              out_ready,
    input  ajb_pkg::ajb_out_t out_data,
    input  logic              pready
);

    // hold a stalled item
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("output item changed while stalled");

    a_dac_format: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.result_kind == ajb_pkg::KIND_DAC |->
            out_data.dac_word_a[15:12] == 4'h3 && out_data.dac_word_b[15:12] == 4'hB)
        else $error("DAC word without control nibble");

    a_dac_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.result_kind != ajb_pkg::KIND_DAC |->
            out_data.dac_word_a == '0 && out_data.dac_word_b == '0)
        else $error("DAC words set on a non-DAC item");

    a_mic_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.result_kind != ajb_pkg::KIND_MIC |->
            out_data.mic_sample == '0 && !out_data.frame_end && pready)
        else $error("mic fields set on a non-mic item");

endmodule

bind audio_jitter_buffer_endpoint_top ajb_checker u_ajb_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .pready    (pready)
);

@@ tb/audio_jitter_buffer_endpoint_top_tb.sv @@
`timescale 1ns / 1ps

module audio_jitter_buffer_endpoint_top_tb;

    import ajb_pkg::*;

    localparam int CYCLE_LIMIT   = 200_000;
    localparam int SETTLE_CYCLES = 8;

    localparam logic [1:0] REQ_SPARE = 2'd3;

    localparam logic [APB_ADDR_W-1:0] ADDR_START_LEVEL  = {REG_START_LEVEL, 2'b00};
    localparam logic [APB_ADDR_W-1:0] ADDR_FILTER_ALPHA = {REG_FILTER_ALPHA, 2'b00};

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    ajb_in_t               in_data;
    logic                  out_valid;
    logic                  out_ready;
    ajb_out_t              out_data;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [31:0]           pwdata;
    logic [31:0]           prdata;
    logic                  pready;

    // Endpoint model state
    logic [SAMPLE_W-1:0] jitter_q[$];
    int                  fill_cnt  = 0;
    bit                  playing   = 1'b0;
    bit                  tx_mode   = 1'b0;
    logic [FS_W-1:0]     mic_avg   = FILTER_STATE_RST;
    int                  frame_pos = 0;
    logic [LEVEL_W-1:0]  lvl_cfg   = START_LEVEL_RST;
    logic [ALPHA_W-1:0]  alpha_cfg = FILTER_ALPHA_RST;

    ajb_out_t audio_result_q[$];
    ajb_out_t want_res;
    int       err_count   = 0;
    int       cycle_count = 0;
    int       stall_left  = 0;
    bit       calm        = 1'b0;

    audio_jitter_buffer_endpoint_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always #10 clk = ~clk;

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
            err_count++;
        end
    endfunction

    function automatic int clamp_fill(input int v);
        if (v > int'(FILL_MAX))
            return int'(FILL_MAX);
        if (v < int'(FILL_MIN))
            return int'(FILL_MIN);
        return v;
    endfunction

    function automatic ajb_in_t pack_req(input logic [1:0] req, input logic [15:0] net,
                                         input logic [11:0] adc);
        ajb_in_t it;
        it.req_type   = req;
        it.net_sample = net;
        it.mic_raw    = adc;
        return it;
    endfunction

    function automatic void advance_endpoint(input ajb_in_t item);
        ajb_out_t            r;
        logic [SAMPLE_W-1:0] left;
        logic [SAMPLE_W-1:0] right;
        longint unsigned     acc;
        r = '0;
        case (item.req_type)
            REQ_NET:
            begin
                // drop the sample when the buffer is full
                if (jitter_q.size() < FIFO_DEPTH)
                begin
                    jitter_q.push_back(item.net_sample);
                    fill_cnt = clamp_fill(fill_cnt + 1);
                end
                if (!playing && fill_cnt >= int'(lvl_cfg))
                    playing = 1'b1;
            end
            REQ_TOGGLE:
            begin
                tx_mode = !tx_mode;
                if (tx_mode)
                begin
                    playing  = 1'b0;
                    fill_cnt = 0;
                end
                frame_pos = 0;
            end
            REQ_TICK:
            begin
                if (tx_mode)
                begin
                    acc = 64'(alpha_cfg) * (64'(item.mic_raw) << FILTER_FRAC_BITS)
                        + (64'd65536 - 64'(alpha_cfg)) * 64'(mic_avg);
                    mic_avg = FS_W'(acc >> ALPHA_W);
                    frame_pos++;
                    r.result_kind = KIND_MIC;
                    r.mic_sample  = mic_avg[FS_W-1 -: ADC_W];
                    if (frame_pos >= FRAME_TICKS)
                    begin
                        frame_pos   = 0;
                        r.frame_end = 1'b1;
                    end
                    audio_result_q.push_back(r);
                end
                else if (playing)
                begin
                    if (jitter_q.size() < 2)
                    begin
                        // a lone left sample is discarded with the underrun
                        if (jitter_q.size() == 1)
                            void'(jitter_q.pop_front());
                        playing       = 1'b0;
                        fill_cnt      = 0;
                        r.result_kind = KIND_UNDERRUN;
                    end
                    else
                    begin
                        left          = jitter_q.pop_front();
                        right         = jitter_q.pop_front();
                        fill_cnt      = clamp_fill(fill_cnt - 2);
                        r.result_kind = KIND_DAC;
                        r.dac_word_a  = DAC_CFG_A | (left & DAC_DATA_MASK);
                        r.dac_word_b  = DAC_CFG_B | (right & DAC_DATA_MASK);
                    end
                    audio_result_q.push_back(r);
                end
            end
            default:
            begin
            end
        endcase
    endfunction

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("audio_jitter_buffer_endpoint_top_tb failed");
            $finish;
        end
    end

    // Output back-pressure in bursts
    always @(posedge clk)
    begin
        if (stall_left > 0)
            stall_left--;
        else if (!calm && $urandom_range(0, 9) == 0)
            stall_left = $urandom_range(1, 7);
        out_ready <= (stall_left == 0);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (audio_result_q.size() == 0)
            begin
                $error("result with nothing pending: kind %0d", out_data.result_kind);
                err_count++;
            end
            else
            begin
                want_res = audio_result_q.pop_front();
                check_field("result_kind", 32'(want_res.result_kind), 32'(out_data.result_kind));
                check_field("dac_word_a", 32'(want_res.dac_word_a), 32'(out_data.dac_word_a));
                check_field("dac_word_b", 32'(want_res.dac_word_b), 32'(out_data.dac_word_b));
                check_field("mic_sample", 32'(want_res.mic_sample), 32'(out_data.mic_sample));
                check_field("frame_end", 32'(want_res.frame_end), 32'(out_data.frame_end));
            end
        end
    end

    task automatic send_item(input ajb_in_t item);
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        do
            @(posedge clk);
        while (!in_ready);
        advance_endpoint(item);
    endtask

    // Hold the input until every pending result is out and the pipeline is quiet
    task automatic drain_results();
        in_valid <= 1'b0;
        while (audio_result_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic apb_access(input bit wr, input logic [APB_ADDR_W-1:0] addr,
                              input logic [31:0] wdata, output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        @(negedge clk);
        rdata = prdata;
        @(posedge clk);
    endtask

    task automatic cfg_write(input logic [APB_ADDR_W-1:0] addr, input logic [31:0] val);
        logic [31:0] rd;
        drain_results();
        apb_access(1'b1, addr, val, rd);
        if (addr == ADDR_START_LEVEL)
            lvl_cfg = val[LEVEL_W-1:0];
        else
            alpha_cfg = val[ALPHA_W-1:0];
        apb_access(1'b0, addr, 32'd0, rd);
        psel    <= 1'b0;
        penable <= 1'b0;
        check_field(addr == ADDR_START_LEVEL ? "start_level readback" : "filter_alpha readback",
                    val, rd);
    endtask

    task automatic test_register_defaults();
        logic [31:0] rd;
        apb_access(1'b0, ADDR_START_LEVEL, 32'd0, rd);
        check_field("start_level reset", 32'(START_LEVEL_RST), rd);
        apb_access(1'b0, ADDR_FILTER_ALPHA, 32'd0, rd);
        check_field("filter_alpha reset", 32'(FILTER_ALPHA_RST), rd);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic test_directed();
        // stopped tick and unused request: no result from either
        send_item(pack_req(REQ_TICK, 16'hFFFF, 12'hFFF));
        send_item(pack_req(REQ_SPARE, 16'hFFFF, 12'hFFF));
        cfg_write(ADDR_START_LEVEL, 32'd0);
        send_item(pack_req(REQ_NET, 16'hFFFF, 12'h000));
        send_item(pack_req(REQ_NET, 16'h0000, 12'hFFF));
        send_item(pack_req(REQ_TICK, 16'h0000, 12'h000));
        // playing with an empty buffer
        send_item(pack_req(REQ_TICK, 16'h5555, 12'hAAA));
        send_item(pack_req(REQ_NET, 16'h8ABC, 12'h555));
        // only one sample held
        send_item(pack_req(REQ_TICK, 16'hAAAA, 12'h000));
        send_item(pack_req(REQ_TOGGLE, 16'h0000, 12'h000));
        send_item(pack_req(REQ_TICK, 16'h0000, 12'hFFF));
        send_item(pack_req(REQ_TICK, 16'hFFFF, 12'h000));
        // arrivals in transmit mode still start playback
        send_item(pack_req(REQ_NET, 16'h5A5A, 12'h800));
        send_item(pack_req(REQ_NET, 16'hA5A5, 12'h7FF));
        send_item(pack_req(REQ_TOGGLE, 16'hFFFF, 12'hFFF));
        send_item(pack_req(REQ_TICK, 16'h1234, 12'h123));
        send_item(pack_req(REQ_TOGGLE, 16'h0000, 12'h000));
        send_item(pack_req(REQ_TOGGLE, 16'h0000, 12'h000));
        send_item(pack_req(REQ_TICK, 16'h0000, 12'h000));
    endtask

    task automatic test_frame_boundary();
        if (!tx_mode)
            send_item(pack_req(REQ_TOGGLE, 16'($urandom), 12'($urandom)));
        repeat (FRAME_TICKS + 3)
            send_item(pack_req(REQ_TICK, 16'($urandom), 12'($urandom)));
    endtask

    task automatic test_random_traffic(input int n_items, input logic [LEVEL_W-1:0] lvl,
                                       input logic [ALPHA_W-1:0] alpha, input bit quiet);
        int         k;
        int         pick;
        logic [1:0] req;
        cfg_write(ADDR_START_LEVEL, 32'(lvl));
        cfg_write(ADDR_FILTER_ALPHA, 32'(alpha));
        calm = quiet;
        for (k = 0; k < n_items; k++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 52)
                req = REQ_NET;
            else if (pick < 92)
                req = REQ_TICK;
            else if (pick < 96)
                req = REQ_TOGGLE;
            else
                req = REQ_SPARE;
            send_item(pack_req(req, 16'($urandom), 12'($urandom)));
        end
    endtask

    initial
    begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        out_ready = 1'b0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_register_defaults();
        test_directed();
        test_frame_boundary();
        test_random_traffic(42, LEVEL_W'(1), 16'hFFFF, 1'b0);
        test_random_traffic(42, LEVEL_W'(0), 16'h0000, 1'b0);
        test_random_traffic(42, LEVEL_W'($urandom_range(0, 24)), 16'($urandom), 1'b0);
        test_random_traffic(42, LEVEL_W'($urandom_range(2, 24)), 16'($urandom), 1'b1);

        drain_results();
        if (err_count == 0 && audio_result_q.size() == 0)
            $display("audio_jitter_buffer_endpoint_top_tb passed");
        else
            $display("audio_jitter_buffer_endpoint_top_tb failed");
        $finish;
    end

endmodule
